// ----- hw/rtl/vdp_pkg.sv -----
// Shared types, constants and the step microprogram for the Van der Pol step engine.
// No dependencies. Used by vdp_ctrl, vdp_datapath and van_der_pol_integrator_step.
package vdp_pkg;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_NEG, OP_MOV, OP_MUL, OP_DIV, OP_LD, OP_TOL
  } op_e;

  typedef enum logic [2:0] {
    CTL_NEXT, CTL_MODE, CTL_END, CTL_SING, CTL_CONV
  } ctl_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOCONV = 2'd1, ST_SINGULAR = 2'd2, ST_SAT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_METHOD = 2'd0, CFG_ALPHA = 2'd1, CFG_TOL = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EX, S_MWB, S_DIV, S_DWB, S_SEQ, S_FIN
  } ctrl_state_e;

  localparam int unsigned PC_W = 7;
  typedef logic [PC_W-1:0] pc_t;
  typedef logic [4:0]      raddr_t;

  localparam logic [30:0] ALPHA_RESET = 31'd83886080;
  localparam logic [24:0] TOL_RESET   = 25'd1;
  localparam int unsigned DIV_STEPS   = 32;

  // scratch register file map
  localparam raddr_t R_X    = 5'd0;
  localparam raddr_t R_V    = 5'd1;
  localparam raddr_t R_DT   = 5'd2;
  localparam raddr_t R_AL   = 5'd3;
  localparam raddr_t R_ONE  = 5'd4;
  localparam raddr_t R_HALF = 5'd5;
  localparam raddr_t R_HDT  = 5'd6;
  localparam raddr_t R_T1   = 5'd7;
  localparam raddr_t R_K1V  = 5'd8;
  localparam raddr_t R_XP   = 5'd9;
  localparam raddr_t R_VP   = 5'd10;
  localparam raddr_t R_K2V  = 5'd11;
  localparam raddr_t R_T2   = 5'd12;
  localparam raddr_t R_XR   = 5'd13;
  localparam raddr_t R_VR   = 5'd14;
  localparam raddr_t R_G0   = 5'd15;
  localparam raddr_t R_A12  = 5'd16;
  localparam raddr_t R_RF   = 5'd17;
  localparam raddr_t R_RG   = 5'd18;
  localparam raddr_t R_TT   = 5'd19;
  localparam raddr_t R_A21  = 5'd20;
  localparam raddr_t R_A22  = 5'd21;
  localparam raddr_t R_DET  = 5'd22;
  localparam raddr_t R_DX   = 5'd23;
  localparam raddr_t R_DV   = 5'd24;
  localparam raddr_t R_T3   = 5'd25;

  // load selects (source A field of OP_LD)
  localparam raddr_t LD_X     = 5'd0;
  localparam raddr_t LD_V     = 5'd1;
  localparam raddr_t LD_DT    = 5'd2;
  localparam raddr_t LD_ALPHA = 5'd3;
  localparam raddr_t LD_ONE   = 5'd4;
  localparam raddr_t LD_HALF  = 5'd5;

  localparam pc_t TRAP_PC = 7'd27;
  localparam pc_t LOOP_PC = 7'd35;

  typedef struct packed {
    op_e    op;
    ctl_e   ctl;
    raddr_t dst;
    raddr_t sa;
    raddr_t sb;
  } uop_t;

  typedef struct packed {
    logic    load_in;
    logic    rd;
    logic    exec;
    logic    mul_wb;
    logic    div_step;
    logic    div_wb;
    logic    capture;
    status_e status;
    uop_t    uop;
  } dp_cmd_t;

  typedef struct packed {
    logic flag;   // last result was zero, or tolerance met after OP_TOL
    logic clamp;  // some intermediate saturated during this transaction
  } dp_stat_t;

  typedef struct packed {
    logic [31:0] val;
    logic        clip;
  } sat_t;

  function automatic sat_t sat33(input logic [32:0] v);
    sat_t r;
    r.clip = v[32] != v[31];
    if (r.clip) begin
      r.val = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input op_e op, input ctl_e ctl, input raddr_t dst,
                              input raddr_t sa, input raddr_t sb);
    uop_t u;
    u.op  = op;
    u.ctl = ctl;
    u.dst = dst;
    u.sa  = sa;
    u.sb  = sb;
    return u;
  endfunction

  // Heun from 7, trapezoidal prologue from 27, Newton body from 35
  function automatic uop_t ucode(input pc_t pc);
    uop_t u;
    u = mk(OP_MOV, CTL_END, R_T1, R_T1, R_T1);
    case (pc)
      7'd0:  u = mk(OP_LD,  CTL_NEXT, R_X,    LD_X,     R_X);
      7'd1:  u = mk(OP_LD,  CTL_NEXT, R_V,    LD_V,     R_X);
      7'd2:  u = mk(OP_LD,  CTL_NEXT, R_DT,   LD_DT,    R_X);
      7'd3:  u = mk(OP_LD,  CTL_NEXT, R_AL,   LD_ALPHA, R_X);
      7'd4:  u = mk(OP_LD,  CTL_NEXT, R_ONE,  LD_ONE,   R_X);
      7'd5:  u = mk(OP_LD,  CTL_NEXT, R_HALF, LD_HALF,  R_X);
      7'd6:  u = mk(OP_MUL, CTL_MODE, R_HDT,  R_DT,     R_HALF);
      7'd7:  u = mk(OP_MUL, CTL_NEXT, R_T1,   R_X,      R_X);
      7'd8:  u = mk(OP_SUB, CTL_NEXT, R_T1,   R_ONE,    R_T1);
      7'd9:  u = mk(OP_MUL, CTL_NEXT, R_T1,   R_AL,     R_T1);
      7'd10: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_T1,     R_V);
      7'd11: u = mk(OP_SUB, CTL_NEXT, R_K1V,  R_T1,     R_X);
      7'd12: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_DT,     R_V);
      7'd13: u = mk(OP_ADD, CTL_NEXT, R_XP,   R_X,      R_T1);
      7'd14: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_DT,     R_K1V);
      7'd15: u = mk(OP_ADD, CTL_NEXT, R_VP,   R_V,      R_T1);
      7'd16: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_XP,     R_XP);
      7'd17: u = mk(OP_SUB, CTL_NEXT, R_T1,   R_ONE,    R_T1);
      7'd18: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_AL,     R_T1);
      7'd19: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_T1,     R_VP);
      7'd20: u = mk(OP_SUB, CTL_NEXT, R_K2V,  R_T1,     R_XP);
      7'd21: u = mk(OP_ADD, CTL_NEXT, R_T1,   R_V,      R_VP);
      7'd22: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_HDT,    R_T1);
      7'd23: u = mk(OP_ADD, CTL_NEXT, R_XR,   R_X,      R_T1);
      7'd24: u = mk(OP_ADD, CTL_NEXT, R_T1,   R_K1V,    R_K2V);
      7'd25: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_HDT,    R_T1);
      7'd26: u = mk(OP_ADD, CTL_END,  R_VR,   R_V,      R_T1);
      7'd27: u = mk(OP_NEG, CTL_NEXT, R_A12,  R_HDT,    R_HDT);
      7'd28: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_X,      R_X);
      7'd29: u = mk(OP_SUB, CTL_NEXT, R_T1,   R_ONE,    R_T1);
      7'd30: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_AL,     R_T1);
      7'd31: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_T1,     R_V);
      7'd32: u = mk(OP_SUB, CTL_NEXT, R_G0,   R_T1,     R_X);
      7'd33: u = mk(OP_MOV, CTL_NEXT, R_XR,   R_X,      R_X);
      7'd34: u = mk(OP_MOV, CTL_NEXT, R_VR,   R_V,      R_V);
      7'd35: u = mk(OP_SUB, CTL_NEXT, R_RF,   R_XR,     R_X);
      7'd36: u = mk(OP_ADD, CTL_NEXT, R_T1,   R_V,      R_VR);
      7'd37: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_HDT,    R_T1);
      7'd38: u = mk(OP_SUB, CTL_NEXT, R_RF,   R_RF,     R_T1);
      7'd39: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_XR,     R_XR);
      7'd40: u = mk(OP_SUB, CTL_NEXT, R_T1,   R_ONE,    R_T1);
      7'd41: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_AL,     R_T1);
      7'd42: u = mk(OP_MUL, CTL_NEXT, R_T2,   R_T1,     R_VR);
      7'd43: u = mk(OP_SUB, CTL_NEXT, R_T2,   R_T2,     R_XR);
      7'd44: u = mk(OP_ADD, CTL_NEXT, R_T2,   R_G0,     R_T2);
      7'd45: u = mk(OP_MUL, CTL_NEXT, R_T2,   R_HDT,    R_T2);
      7'd46: u = mk(OP_SUB, CTL_NEXT, R_RG,   R_VR,     R_V);
      7'd47: u = mk(OP_SUB, CTL_NEXT, R_RG,   R_RG,     R_T2);
      7'd48: u = mk(OP_MUL, CTL_NEXT, R_TT,   R_XR,     R_VR);
      7'd49: u = mk(OP_MUL, CTL_NEXT, R_TT,   R_AL,     R_TT);
      7'd50: u = mk(OP_ADD, CTL_NEXT, R_A21,  R_TT,     R_TT);
      7'd51: u = mk(OP_ADD, CTL_NEXT, R_A21,  R_A21,    R_ONE);
      7'd52: u = mk(OP_MUL, CTL_NEXT, R_A21,  R_HDT,    R_A21);
      // damping term in T1 is still alpha*(1 - x1^2)
      7'd53: u = mk(OP_MUL, CTL_NEXT, R_A22,  R_HDT,    R_T1);
      7'd54: u = mk(OP_SUB, CTL_NEXT, R_A22,  R_ONE,    R_A22);
      7'd55: u = mk(OP_MUL, CTL_NEXT, R_T3,   R_A12,    R_A21);
      7'd56: u = mk(OP_SUB, CTL_SING, R_DET,  R_A22,    R_T3);
      7'd57: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_RF,     R_A22);
      7'd58: u = mk(OP_NEG, CTL_NEXT, R_T1,   R_T1,     R_T1);
      7'd59: u = mk(OP_MUL, CTL_NEXT, R_T2,   R_RG,     R_A12);
      7'd60: u = mk(OP_ADD, CTL_NEXT, R_T1,   R_T1,     R_T2);
      7'd61: u = mk(OP_DIV, CTL_NEXT, R_DX,   R_T1,     R_DET);
      7'd62: u = mk(OP_MUL, CTL_NEXT, R_T1,   R_RF,     R_A21);
      7'd63: u = mk(OP_SUB, CTL_NEXT, R_T1,   R_T1,     R_RG);
      7'd64: u = mk(OP_DIV, CTL_NEXT, R_DV,   R_T1,     R_DET);
      7'd65: u = mk(OP_ADD, CTL_NEXT, R_XR,   R_XR,     R_DX);
      7'd66: u = mk(OP_ADD, CTL_NEXT, R_VR,   R_VR,     R_DV);
      7'd67: u = mk(OP_TOL, CTL_CONV, R_T1,   R_DX,     R_DV);
      default: u = mk(OP_MOV, CTL_END, R_T1, R_T1, R_T1);
    endcase
    return u;
  endfunction

endpackage

// ----- hw/rtl/vdp_datapath.sv -----
// Datapath: scratch register file, saturating add/sub, 32x32 multiplier with
// rounding, bit-serial divider, and the result registers. Depends on vdp_pkg.
module vdp_datapath #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vdp_pkg::dp_cmd_t  cmd_i,
  input  logic [31:0]       position_now_i,
  input  logic [31:0]       velocity_now_i,
  input  logic [30:0]       time_step_i,
  input  logic [30:0]       alpha_i,
  input  logic [24:0]       tol_i,
  output vdp_pkg::dp_stat_t stat_o,
  output logic [31:0]       position_next_o,
  output logic [31:0]       velocity_next_o,
  output logic [1:0]        step_status_o
);

  localparam int unsigned NW = 33 + FRAC_BITS;
  localparam logic [31:0] FX_ONE  = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] FX_HALF = 32'(64'd1 << (FRAC_BITS - 1));
  localparam logic [63:0] RND     = 64'd1 << (FRAC_BITS - 1);

  logic [31:0] x_in_q, v_in_q;
  logic [30:0] dt_in_q;
  logic [31:0] rf_mem [32];
  logic [31:0] rda_q, rdb_q;
  logic [63:0] prod_q;
  logic [31:0] rem_q, nlo_q, dvs_q, quo_q;
  logic        neg_q, big_q;
  logic        clamp_q, flag_q;
  logic [31:0] xr_q, vr_q, pos_q, vel_q;
  logic [1:0]  status_q;

  vdp_pkg::sat_t alu_s, mul_s, div_s, wr_s;
  logic        we;
  logic [31:0] ld_val;
  logic [63:0] rnd_sum, shifted;
  logic [32:0] hi_bits;
  logic [31:0] abs_a, abs_b, m_ab;
  logic [NW-1:0] nnum;
  logic [FRAC_BITS:0] nhi;
  logic [32:0] r2;
  logic        ge;
  logic        conv;

  assign abs_a = rda_q[31] ? 32'(~rda_q + 32'd1) : rda_q;
  assign abs_b = rdb_q[31] ? 32'(~rdb_q + 32'd1) : rdb_q;
  assign m_ab  = (abs_a > abs_b) ? abs_a : abs_b;
  assign conv  = m_ab < 32'(tol_i);

  always_comb begin
    ld_val = FX_HALF;
    case (cmd_i.uop.sa)
      vdp_pkg::LD_X:     ld_val = x_in_q;
      vdp_pkg::LD_V:     ld_val = v_in_q;
      vdp_pkg::LD_DT:    ld_val = {1'b0, dt_in_q};
      vdp_pkg::LD_ALPHA: ld_val = {1'b0, alpha_i};
      vdp_pkg::LD_ONE:   ld_val = FX_ONE;
      default:           ld_val = FX_HALF;
    endcase
  end

  always_comb begin
    alu_s.clip = 1'b0;
    alu_s.val  = rda_q;
    case (cmd_i.uop.op)
      vdp_pkg::OP_ADD: alu_s = vdp_pkg::sat33({rda_q[31], rda_q} + {rdb_q[31], rdb_q});
      vdp_pkg::OP_SUB: alu_s = vdp_pkg::sat33({rda_q[31], rda_q} - {rdb_q[31], rdb_q});
      vdp_pkg::OP_NEG: alu_s = vdp_pkg::sat33(33'd0 - {rda_q[31], rda_q});
      vdp_pkg::OP_LD:  alu_s.val = ld_val;
      default:         alu_s.val = rda_q;
    endcase
  end

  // product: add half an LSB, floor shift, clamp to 32 bits
  always_comb begin
    rnd_sum    = prod_q + RND;
    shifted    = $signed(rnd_sum) >>> FRAC_BITS;
    hi_bits    = shifted[63:31];
    mul_s.clip = !((&hi_bits) || !(|hi_bits));
    if (mul_s.clip) begin
      mul_s.val = shifted[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      mul_s.val = shifted[31:0];
    end
  end

  // numerator |n|*2^F + |d|/2; quotient of 2^32 or more always clamps
  assign nnum = (NW'(abs_a) << FRAC_BITS) + NW'(abs_b >> 1);
  assign nhi  = nnum[NW-1:32];
  assign r2   = {rem_q, nlo_q[31]};
  assign ge   = r2 >= {1'b0, dvs_q};

  always_comb begin
    div_s.clip = 1'b0;
    div_s.val  = quo_q;
    if (big_q) begin
      div_s.clip = 1'b1;
      div_s.val  = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_q) begin
      if (quo_q > 32'h8000_0000) begin
        div_s.clip = 1'b1;
        div_s.val  = 32'h8000_0000;
      end else begin
        div_s.val = 32'(~quo_q + 32'd1);
      end
    end else if (quo_q[31]) begin
      div_s.clip = 1'b1;
      div_s.val  = 32'h7FFF_FFFF;
    end
  end

  assign we = (cmd_i.exec && cmd_i.uop.op != vdp_pkg::OP_MUL &&
               cmd_i.uop.op != vdp_pkg::OP_DIV && cmd_i.uop.op != vdp_pkg::OP_TOL) ||
              cmd_i.mul_wb || cmd_i.div_wb;
  assign wr_s = cmd_i.mul_wb ? mul_s : (cmd_i.div_wb ? div_s : alu_s);

  always_ff @(posedge clk_i) begin
    if (we) begin
      rf_mem[cmd_i.uop.dst] <= wr_s.val;
    end
    if (cmd_i.rd) begin
      rda_q <= rf_mem[cmd_i.uop.sa];
      rdb_q <= rf_mem[cmd_i.uop.sb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_in_q  <= position_now_i;
      v_in_q  <= velocity_now_i;
      dt_in_q <= time_step_i;
    end
    if (cmd_i.exec && cmd_i.uop.op == vdp_pkg::OP_MUL) begin
      prod_q <= 64'($signed(rda_q) * $signed(rdb_q));
    end
    if (cmd_i.exec && cmd_i.uop.op == vdp_pkg::OP_DIV) begin
      rem_q <= 32'(nhi);
      nlo_q <= nnum[31:0];
      dvs_q <= abs_b;
      neg_q <= rda_q[31] ^ rdb_q[31];
      big_q <= 32'(nhi) >= abs_b;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(r2 - {1'b0, dvs_q}) : r2[31:0];
      nlo_q <= {nlo_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], ge};
    end
    if (we && cmd_i.uop.dst == vdp_pkg::R_XR) begin
      xr_q <= wr_s.val;
    end
    if (we && cmd_i.uop.dst == vdp_pkg::R_VR) begin
      vr_q <= wr_s.val;
    end
    if (cmd_i.capture) begin
      pos_q    <= xr_q;
      vel_q    <= vr_q;
      status_q <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        clamp_q <= 1'b0;
      end else if (we && wr_s.clip) begin
        clamp_q <= 1'b1;
      end
      if (cmd_i.exec && cmd_i.uop.op == vdp_pkg::OP_TOL) begin
        flag_q <= conv;
      end else if (we) begin
        flag_q <= wr_s.val == 32'd0;
      end
    end
  end

  assign stat_o.flag      = flag_q;
  assign stat_o.clamp     = clamp_q;
  assign position_next_o  = pos_q;
  assign velocity_next_o  = vel_q;
  assign step_status_o    = status_q;

endmodule

// ----- hw/rtl/vdp_ctrl.sv -----
// Controller: microprogram sequencer, Newton iteration count and the output
// handshake. Drives vdp_datapath through dp_cmd_t. Depends on vdp_pkg.
module vdp_ctrl #(
  parameter int unsigned MAX_NEWTON_ITERS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              method_i,
  input  vdp_pkg::dp_stat_t stat_i,
  output vdp_pkg::dp_cmd_t  cmd_o
);

  localparam int unsigned IT_W = (MAX_NEWTON_ITERS > 1) ? $clog2(MAX_NEWTON_ITERS) : 1;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(MAX_NEWTON_ITERS - 1);
  localparam logic [4:0] DIV_LAST = 5'(vdp_pkg::DIV_STEPS - 1);

  vdp_pkg::ctrl_state_e state_q, state_d;
  vdp_pkg::pc_t         pc_q, pc_d;
  logic [IT_W-1:0]      iter_q, iter_d;
  logic [4:0]           divcnt_q, divcnt_d;
  vdp_pkg::status_e     fin_q, fin_d;
  logic                 out_valid_q, out_valid_d;
  vdp_pkg::uop_t        uop;
  vdp_pkg::status_e     ok_code;

  assign uop     = vdp_pkg::ucode(pc_q);
  assign ok_code = stat_i.clamp ? vdp_pkg::ST_SAT : vdp_pkg::ST_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdp_pkg::S_IDLE;
      pc_q        <= '0;
      iter_q      <= '0;
      divcnt_q    <= '0;
      fin_q       <= vdp_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      iter_q      <= iter_d;
      divcnt_q    <= divcnt_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    iter_d        = iter_q;
    divcnt_d      = divcnt_q;
    fin_d         = fin_q;
    cmd_o         = '0;
    cmd_o.uop     = uop;
    cmd_o.status  = fin_q;
    case (state_q)
      vdp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          pc_d          = '0;
          iter_d        = '0;
          state_d       = vdp_pkg::S_RD;
        end
      end
      vdp_pkg::S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = vdp_pkg::S_EX;
      end
      vdp_pkg::S_EX: begin
        cmd_o.exec = 1'b1;
        if (uop.op == vdp_pkg::OP_MUL) begin
          state_d = vdp_pkg::S_MWB;
        end else if (uop.op == vdp_pkg::OP_DIV) begin
          divcnt_d = '0;
          state_d  = vdp_pkg::S_DIV;
        end else begin
          state_d = vdp_pkg::S_SEQ;
        end
      end
      vdp_pkg::S_MWB: begin
        cmd_o.mul_wb = 1'b1;
        state_d      = vdp_pkg::S_SEQ;
      end
      vdp_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        divcnt_d       = divcnt_q + 5'd1;
        if (divcnt_q == DIV_LAST) begin
          state_d = vdp_pkg::S_DWB;
        end
      end
      vdp_pkg::S_DWB: begin
        cmd_o.div_wb = 1'b1;
        state_d      = vdp_pkg::S_SEQ;
      end
      vdp_pkg::S_SEQ: begin
        pc_d    = pc_q + 1'b1;
        state_d = vdp_pkg::S_RD;
        case (uop.ctl)
          vdp_pkg::CTL_MODE: begin
            if (method_i) begin
              pc_d = vdp_pkg::TRAP_PC;
            end
          end
          vdp_pkg::CTL_END: begin
            fin_d   = ok_code;
            state_d = vdp_pkg::S_FIN;
          end
          vdp_pkg::CTL_SING: begin
            if (stat_i.flag) begin
              fin_d   = vdp_pkg::ST_SINGULAR;
              state_d = vdp_pkg::S_FIN;
            end
          end
          vdp_pkg::CTL_CONV: begin
            if (stat_i.flag) begin
              fin_d   = ok_code;
              state_d = vdp_pkg::S_FIN;
            end else if (iter_q == IT_LAST) begin
              fin_d   = vdp_pkg::ST_NOCONV;
              state_d = vdp_pkg::S_FIN;
            end else begin
              iter_d = iter_q + 1'b1;
              pc_d   = vdp_pkg::LOOP_PC;
            end
          end
          default: ;
        endcase
      end
      vdp_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.capture = 1'b1;
          state_d       = vdp_pkg::S_IDLE;
        end
      end
      default: state_d = vdp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = state_q != vdp_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while held");

  a_div_count_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vdp_pkg::S_EX && uop.op == vdp_pkg::OP_DIV) |=> divcnt_q == 5'd0)
    else $error("divider count not cleared");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= IT_LAST)
    else $error("iteration count beyond limit");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vdp_pkg::S_IDLE && in_valid_i) |=> (state_q == vdp_pkg::S_RD && pc_q == '0))
    else $error("accepted transaction did not start program");

endmodule

// ----- hw/rtl/van_der_pol_integrator_step.sv -----
// One Van der Pol step (x' = v, v' = alpha(1-x^2)v - x) in signed fixed point.
// Top level: configuration registers, vdp_ctrl and vdp_datapath. Uses vdp_pkg.
//
// The block takes one transaction at a time. A multiply micro-operation goes through
// register-file read, execute, multiplier write-back and sequence. Add, subtract,
// negate, move, load and the tolerance check go through read, execute and sequence.
// A divide goes through read, execute, the divider steps, divide write-back and
// sequence; the divider retires one quotient bit per cycle. A Heun step
// (method_select 0) runs the loads and the Heun body. A trapezoidal step
// (method_select 1) runs its setup and then up to MAX_NEWTON_ITERS Newton iterations;
// a zero determinant ends it part way through an iteration. The block returns to
// idle between transactions. A finished result is held on the output while the next
// transaction is taken and computed; that one waits at its end until the held result
// is taken.
module van_der_pol_integrator_step #(
  parameter int unsigned MAX_NEWTON_ITERS = 32,
  parameter int unsigned FRAC_BITS        = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] position_now_i,
  input  logic [31:0] velocity_now_i,
  input  logic [30:0] time_step_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] position_next_o,
  output logic [31:0] velocity_next_o,
  output logic [1:0]  step_status_o
);

  logic        method_q;
  logic [30:0] alpha_q;
  logic [24:0] tol_q;

  vdp_pkg::dp_cmd_t  cmd;
  vdp_pkg::dp_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= 1'b0;
      alpha_q  <= vdp_pkg::ALPHA_RESET;
      tol_q    <= vdp_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vdp_pkg::CFG_METHOD: method_q <= cfg_data_i[0];
        vdp_pkg::CFG_ALPHA:  alpha_q  <= cfg_data_i;
        vdp_pkg::CFG_TOL:    tol_q    <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  vdp_ctrl #(
    .MAX_NEWTON_ITERS(MAX_NEWTON_ITERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .method_i   (method_q),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vdp_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .position_now_i (position_now_i),
    .velocity_now_i (velocity_now_i),
    .time_step_i    (time_step_i),
    .alpha_i        (alpha_q),
    .tol_i          (tol_q),
    .stat_o         (stat),
    .position_next_o(position_next_o),
    .velocity_next_o(velocity_next_o),
    .step_status_o  (step_status_o)
  );

endmodule

// ----- bench/van_der_pol_integrator_step_tb.sv -----
// Self-checking bench for van_der_pol_integrator_step: directed table, then random phases.
// Depends on vdp_pkg and the RTL top. Every result is checked against the table or a fixed-point step predictor.
module van_der_pol_integrator_step_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NEWTON_ITERS = 32;
  localparam int unsigned FRAC         = 24;
  localparam longint      CYCLE_LIMIT  = 60_000_000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;  // index past the register list

  typedef logic signed [31:0] fx_t;
  localparam fx_t FX_ONE  = 32'sh0100_0000;
  localparam fx_t FX_HALF = 32'sh0080_0000;
  localparam fx_t FX_MAX  = 32'sh7FFF_FFFF;
  localparam fx_t FX_MIN  = 32'sh8000_0000;
  localparam logic [30:0] ALPHA_MAX = 31'h7FFF_FFFF;
  localparam logic [24:0] TOL_MAX   = 25'h100_0000;

  typedef struct {
    fx_t              pos;
    fx_t              vel;
    vdp_pkg::status_e st;
  } step_t;

  typedef struct {
    logic        mode;
    logic [30:0] alpha;
    logic [24:0] tol;
    fx_t         x;
    fx_t         v;
    logic [30:0] dt;
    logic        known;
    step_t       want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] position_now_i = '0;
  logic [31:0] velocity_now_i = '0;
  logic [30:0] time_step_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] position_next_o;
  logic [31:0] velocity_next_o;
  logic [1:0]  step_status_o;

  van_der_pol_integrator_step i_dut (.*);

  always #4 clk_i = ~clk_i;

  // shadow copy of the configuration registers
  logic        cfg_method = 1'b0;
  logic [30:0] cfg_alpha  = vdp_pkg::ALPHA_RESET;
  logic [24:0] cfg_tol    = vdp_pkg::TOL_RESET;

  step_t  pending_steps[$];
  int     mismatches = 0;
  int     checked = 0;
  int     sent_heun = 0;
  int     sent_trap = 0;
  int     status_seen[4] = '{0, 0, 0, 0};
  longint cycles = 0;
  bit     sat_hit;
  bit     no_gaps = 1'b0;
  bit     hold_req = 1'b0;

  // ---------------- fixed-point step predictor ----------------
  function automatic fx_t clip(input longint v);
    if (v > longint'(FX_MAX)) begin
      sat_hit = 1'b1;
      return FX_MAX;
    end
    if (v < longint'(FX_MIN)) begin
      sat_hit = 1'b1;
      return FX_MIN;
    end
    return fx_t'(v);
  endfunction

  function automatic fx_t fadd(input fx_t a, input fx_t b);
    return clip(longint'(a) + longint'(b));
  endfunction

  function automatic fx_t fsub(input fx_t a, input fx_t b);
    return clip(longint'(a) - longint'(b));
  endfunction

  function automatic fx_t fneg(input fx_t a);
    return clip(-longint'(a));
  endfunction

  function automatic longint mag(input fx_t a);
    return (a < 0) ? -longint'(a) : longint'(a);
  endfunction

  // round half up, floor after the offset
  function automatic fx_t fmul(input fx_t a, input fx_t b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC - 1));
    return clip(p >>> FRAC);
  endfunction

  // round half away from zero; divisor is never zero here
  function automatic fx_t fdiv(input fx_t n, input fx_t d);
    logic [63:0] un, ud, q;
    un = 64'(mag(n)) << FRAC;
    ud = 64'(mag(d));
    q  = (un + ud / 2) / ud;
    return clip(((n < 0) != (d < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic fx_t accel(input fx_t x, input fx_t v, input fx_t alpha);
    fx_t damp;
    damp = fmul(alpha, fsub(FX_ONE, fmul(x, x)));
    return fsub(fmul(damp, v), x);
  endfunction

  function automatic step_t predict_step(input fx_t x, input fx_t v, input logic [30:0] dt_u);
    fx_t    alpha, dt, hdt, k1v, xp, vp, k2v, a12, g0, x1, v1;
    fx_t    rf, rg, t, a21, a22, det, dx, dv;
    longint m;
    step_t  r;
    alpha = fx_t'({1'b0, cfg_alpha});
    dt    = fx_t'({1'b0, dt_u});
    sat_hit = 1'b0;
    hdt = fmul(dt, FX_HALF);
    if (!cfg_method) begin
      k1v = accel(x, v, alpha);
      xp  = fadd(x, fmul(dt, v));
      vp  = fadd(v, fmul(dt, k1v));
      k2v = accel(xp, vp, alpha);
      r.pos = fadd(x, fmul(hdt, fadd(v, vp)));
      r.vel = fadd(v, fmul(hdt, fadd(k1v, k2v)));
      r.st  = vdp_pkg::ST_OK;
    end else begin
      a12 = fneg(hdt);
      g0  = accel(x, v, alpha);
      x1  = x;
      v1  = v;
      r.st = vdp_pkg::ST_NOCONV;
      for (int it = 0; it < NEWTON_ITERS; it++) begin
        rf  = fsub(fsub(x1, x), fmul(hdt, fadd(v, v1)));
        rg  = fsub(fsub(v1, v), fmul(hdt, fadd(g0, accel(x1, v1, alpha))));
        t   = fmul(alpha, fmul(x1, v1));
        a21 = fmul(hdt, fadd(fadd(t, t), FX_ONE));
        a22 = fsub(FX_ONE, fmul(hdt, fmul(alpha, fsub(FX_ONE, fmul(x1, x1)))));
        det = fsub(a22, fmul(a12, a21));
        if (det == 0) begin
          r.st = vdp_pkg::ST_SINGULAR;
          break;
        end
        dx = fdiv(fadd(fneg(fmul(rf, a22)), fmul(rg, a12)), det);
        dv = fdiv(fsub(fmul(rf, a21), rg), det);
        x1 = fadd(x1, dx);
        v1 = fadd(v1, dv);
        m  = (mag(dx) > mag(dv)) ? mag(dx) : mag(dv);
        if (m < longint'(cfg_tol)) begin
          r.st = vdp_pkg::ST_OK;
          break;
        end
      end
      r.pos = x1;
      r.vel = v1;
    end
    if (r.st == vdp_pkg::ST_OK && sat_hit) r.st = vdp_pkg::ST_SAT;
    return r;
  endfunction

  // ---------------- stimulus side ----------------
  task automatic wait_idle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    // one transaction is never in flight without an expectation, small margin only
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [30:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    case (idx)
      vdp_pkg::CFG_METHOD: cfg_method = data[0];
      vdp_pkg::CFG_ALPHA:  cfg_alpha  = data;
      vdp_pkg::CFG_TOL:    cfg_tol    = data[24:0];
      default: ;
    endcase
  endtask

  // junk in the unused upper bits checks the write masking
  task automatic set_cfg(input logic mode, input logic [30:0] alpha, input logic [24:0] tol);
    wait_idle();
    cfg_write(vdp_pkg::CFG_METHOD, (31'($urandom) & 31'h7FFF_FFFE) | 31'(mode));
    cfg_write(vdp_pkg::CFG_ALPHA, alpha);
    cfg_write(vdp_pkg::CFG_TOL, {6'($urandom), tol});
  endtask

  task automatic send_step(input fx_t x, input fx_t v, input logic [30:0] dt,
                           input logic known, input step_t want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    position_now_i <= x;
    velocity_now_i <= v;
    time_step_i    <= dt;
    do @(posedge clk_i); while (in_stall_o);
    pending_steps = {pending_steps, (known ? want : predict_step(x, v, dt))};
    if (cfg_method) sent_trap++;
    else sent_heun++;
  endtask

  function automatic fx_t pick_edge();
    case ($urandom_range(0, 5))
      0: return FX_MAX;
      1: return FX_MIN;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return FX_ONE;
    endcase
  endfunction

  task automatic send_random();
    int    r;
    fx_t   x, v;
    logic [30:0] dt;
    step_t none;
    none = '{0, 0, vdp_pkg::ST_OK};
    r = $urandom_range(0, 99);
    if (r < 15) begin
      x  = $urandom;
      v  = $urandom;
      dt = 31'($urandom);
    end else if (r < 25) begin
      x  = pick_edge();
      v  = pick_edge();
      dt = ($urandom_range(0, 1) != 0) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 2)) << 23;
    end else begin
      // trajectory-like values: |x| <= 4, |v| <= 8, dt <= 0.5
      x  = fx_t'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      v  = fx_t'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
      dt = 31'($urandom_range(0, 32'h0080_0000));
    end
    send_step(x, v, dt, 1'b0, none);
  endtask

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) send_random();
  endtask

  // ---------------- result side ----------------
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    step_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_steps.size() == 0) begin
        $error("result with no transaction pending: pos %h vel %h status %0d",
               position_next_o, velocity_next_o, step_status_o);
        mismatches++;
      end else begin
        want = pending_steps.pop_front();
        checked++;
        status_seen[step_status_o]++;
        if (position_next_o !== want.pos) begin
          $error("position_next: expected %h, got %h", want.pos, position_next_o);
          mismatches++;
        end
        if (velocity_next_o !== want.vel) begin
          $error("velocity_next: expected %h, got %h", want.vel, velocity_next_o);
          mismatches++;
        end
        if (step_status_o !== want.st) begin
          $error("step_status: expected %0d, got %0d", want.st, step_status_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_steps.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    dir_row_t dir_rows[$];
    dir_rows = '{
      // reset configuration: Heun, alpha 5.0
      '{1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, 0, 0, 31'd0, 1'b1,
        '{0, 0, vdp_pkg::ST_OK}},
      '{1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, FX_MAX, FX_MIN, 31'd0, 1'b1,
        '{FX_MAX, FX_MIN, vdp_pkg::ST_SAT}},
      '{1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, FX_MIN, FX_MAX, 31'd0, 1'b1,
        '{FX_MIN, FX_MAX, vdp_pkg::ST_SAT}},
      '{1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, 0, 0, 31'h7FFF_FFFF, 1'b1,
        '{0, 0, vdp_pkg::ST_OK}},
      '{1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, FX_ONE, 0, 31'h0002_8F5C, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}},
      '{1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, -32'sh0200_0000, 32'sh0300_0000,
        31'h0019_999A, 1'b0, '{0, 0, vdp_pkg::ST_OK}},
      '{1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, 1, -1, 31'd1, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}},
      '{1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, FX_MAX, FX_MAX, 31'h7FFF_FFFF, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}},
      // Heun with extreme damping
      '{1'b0, 31'd0, vdp_pkg::TOL_RESET, FX_ONE, FX_ONE, 31'h0010_0000, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}},
      '{1'b0, ALPHA_MAX, vdp_pkg::TOL_RESET, FX_ONE, FX_ONE, 31'h0010_0000, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}},
      // trapezoidal: at rest, converges at once
      '{1'b1, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, 0, 0, 31'h0002_8F5C, 1'b1,
        '{0, 0, vdp_pkg::ST_OK}},
      '{1'b1, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, 32'sh0200_0000, 0, 31'h0002_8F5C,
        1'b0, '{0, 0, vdp_pkg::ST_OK}},
      '{1'b1, vdp_pkg::ALPHA_RESET, 25'h000_1000, -32'sh0100_0000, 32'sh0080_0000,
        31'h0040_0000, 1'b0, '{0, 0, vdp_pkg::ST_OK}},
      '{1'b1, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET, FX_MAX, FX_MIN, 31'h0100_0000, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}},
      // alpha 2.5, dt 1.0, x 0: Jacobian determinant is exactly zero
      '{1'b1, 31'h0280_0000, vdp_pkg::TOL_RESET, 0, 0, 31'h0100_0000, 1'b1,
        '{0, 0, vdp_pkg::ST_SINGULAR}},
      '{1'b1, 31'h0280_0000, vdp_pkg::TOL_RESET, 0, FX_ONE, 31'h0100_0000, 1'b1,
        '{0, FX_ONE, vdp_pkg::ST_SINGULAR}},
      // zero tolerance never converges; widest tolerance (1.0) stops at the first update below it
      '{1'b1, FX_ONE[30:0], 25'd0, FX_ONE, 0, 31'h0004_0000, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}},
      '{1'b1, FX_ONE[30:0], TOL_MAX, FX_ONE, FX_ONE, 31'h0004_0000, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}},
      '{1'b1, 31'd0, TOL_MAX, FX_MIN, FX_MAX, 31'h7FFF_FFFF, 1'b0,
        '{0, 0, vdp_pkg::ST_OK}}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (i > 0 && (dir_rows[i].mode != cfg_method || dir_rows[i].alpha != cfg_alpha ||
                    dir_rows[i].tol != cfg_tol))
        set_cfg(dir_rows[i].mode, dir_rows[i].alpha, dir_rows[i].tol);
      send_step(dir_rows[i].x, dir_rows[i].v, dir_rows[i].dt, dir_rows[i].known,
                dir_rows[i].want);
    end

    // an index past the register list must leave everything untouched
    set_cfg(1'b0, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET);
    cfg_write(CFG_UNUSED, 31'($urandom));

    // long output hold-off while inputs keep coming, so the input side backs up
    hold_req = 1'b1;
    run_phase(300);

    set_cfg(1'b0, 31'd0, vdp_pkg::TOL_RESET);
    run_phase(150);
    set_cfg(1'b0, ALPHA_MAX, vdp_pkg::TOL_RESET);
    run_phase(150);

    set_cfg(1'b0, 31'($urandom_range(0, 32'h0A00_0000)), 25'($urandom));
    no_gaps = 1'b1;
    run_phase(150);
    no_gaps = 1'b0;
    // sender waits for every result before going on
    wait_idle();
    run_phase(150);

    set_cfg(1'b1, FX_ONE[30:0], 25'h000_0100);
    run_phase(200);
    set_cfg(1'b1, 31'($urandom_range(0, 32'h0400_0000)), TOL_MAX);
    run_phase(150);
    set_cfg(1'b1, vdp_pkg::ALPHA_RESET, vdp_pkg::TOL_RESET);
    no_gaps = 1'b1;
    run_phase(100);
    no_gaps = 1'b0;
    set_cfg(1'b1, ALPHA_MAX, 25'h000_1000);
    run_phase(60);
    set_cfg(1'b1, 31'($urandom), 25'd0);
    run_phase(15);

    set_cfg(1'b0, 31'($urandom), 25'($urandom));
    run_phase(200);

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d Heun and %0d trapezoidal steps, %0d results checked",
             sent_heun, sent_trap, checked);
    $display("status counts ok/noconv/singular/sat: %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/vdp_pkg.sv
hw/rtl/vdp_datapath.sv
hw/rtl/vdp_ctrl.sv
hw/rtl/van_der_pol_integrator_step.sv
bench/van_der_pol_integrator_step_tb.sv
